>>> design/cc20_pkg.sv
// Shared types, constants and helper functions for the ChaCha20 byte stream cipher.
`timescale 1ns / 1ps
package cc20_pkg;

  localparam int unsigned DoubleRoundsDefault = 10;
  localparam int unsigned QueueDepth = 2;
  localparam int unsigned CfgIdxW = 3;
  localparam int unsigned CfgDataW = 64;

  localparam logic [CfgIdxW-1:0] CFG_KEY_01   = 3'd0;
  localparam logic [CfgIdxW-1:0] CFG_KEY_23   = 3'd1;
  localparam logic [CfgIdxW-1:0] CFG_KEY_45   = 3'd2;
  localparam logic [CfgIdxW-1:0] CFG_KEY_67   = 3'd3;
  localparam logic [CfgIdxW-1:0] CFG_NONCE_01 = 3'd4;
  localparam logic [CfgIdxW-1:0] CFG_NONCE_2  = 3'd5;
  localparam logic [CfgIdxW-1:0] CFG_START    = 3'd6;

  localparam logic [31:0] SIGMA_0 = 32'h6578_7061;
  localparam logic [31:0] SIGMA_1 = 32'h6E64_2033;
  localparam logic [31:0] SIGMA_2 = 32'h322D_6279;
  localparam logic [31:0] SIGMA_3 = 32'h7465_206B;

  typedef logic [15:0][31:0] block_t;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
  } item_t;

  typedef struct packed {
    logic start;
    logic done;
  } core_ctl_t;

  typedef enum logic [1:0] {
    CORE_IDLE,
    CORE_RUN,
    CORE_ADD
  } core_state_e;

  // State word index of one row of a quarter round lane, for column or diagonal rounds.
  function automatic logic [3:0] lane_idx(input logic [1:0] lane, input logic diag,
                                          input logic [1:0] row);
    logic [1:0] col;
    col = diag ? (lane + row) : lane;
    return {row, col};
  endfunction

  function automatic logic [31:0] rotl(input logic [31:0] x, input int unsigned n);
    return (x << n) | (x >> (32 - n));
  endfunction

endpackage

>>> design/cc20_front.sv
// Input queue that accepts transactions and holds them for the keystream back end.
`timescale 1ns / 1ps
module cc20_front (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_stall_o,
  input  cc20_pkg::item_t  item_i,
  output logic             head_valid_o,
  output cc20_pkg::item_t  head_o,
  input  logic             pop_i
);
  import cc20_pkg::*;

  localparam int unsigned PtrW = $clog2(QueueDepth);
  localparam int unsigned CntW = $clog2(QueueDepth + 1);

  item_t            mem_q [QueueDepth];
  logic [PtrW-1:0]  wr_q, wr_d, rd_q, rd_d;
  logic [CntW-1:0]  cnt_q, cnt_d;
  logic             push, pop;

  assign in_stall_o   = (cnt_q == CntW'(QueueDepth));
  assign push         = in_valid_i && !in_stall_o;
  assign head_valid_o = (cnt_q != '0);
  assign pop          = pop_i && head_valid_o;
  assign head_o       = mem_q[rd_q];

  always_comb begin
    wr_d  = push ? ((wr_q == PtrW'(QueueDepth - 1)) ? '0 : wr_q + 1'b1) : wr_q;
    rd_d  = pop  ? ((rd_q == PtrW'(QueueDepth - 1)) ? '0 : rd_q + 1'b1) : rd_q;
    cnt_d = cnt_q + CntW'(push) - CntW'(pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_q] <= item_i;
    end
  end

endmodule

>>> design/cc20_core.sv
// Iterative ChaCha20 block function: one quarter-round line of all four lanes per cycle.
`timescale 1ns / 1ps
module cc20_core #(
  parameter int unsigned DOUBLE_ROUNDS = cc20_pkg::DoubleRoundsDefault
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  cc20_pkg::block_t    init_i,
  input  logic                start_i,
  output cc20_pkg::core_ctl_t ctl_o,
  output cc20_pkg::block_t    ks_o
);
  import cc20_pkg::*;

  localparam int unsigned DrW = $clog2(DOUBLE_ROUNDS);

  core_state_e     state_q, state_d;
  block_t          work_q, work_d, init_q;
  logic [1:0]      sub_q, sub_d;
  logic            diag_q, diag_d;
  logic [DrW-1:0]  dr_q, dr_d;
  block_t          step;

  // One line of the quarter round, applied to the four lanes at once.
  always_comb begin
    logic [3:0]  ia, ib, ic, id;
    logic [31:0] sum;
    step = work_q;
    for (int l = 0; l < 4; l++) begin
      ia = lane_idx(2'(l), diag_q, 2'd0);
      ib = lane_idx(2'(l), diag_q, 2'd1);
      ic = lane_idx(2'(l), diag_q, 2'd2);
      id = lane_idx(2'(l), diag_q, 2'd3);
      case (sub_q)
        2'd0: begin
          sum = work_q[ia] + work_q[ib];
          step[ia] = sum;
          step[id] = rotl(work_q[id] ^ sum, 16);
        end
        2'd1: begin
          sum = work_q[ic] + work_q[id];
          step[ic] = sum;
          step[ib] = rotl(work_q[ib] ^ sum, 12);
        end
        2'd2: begin
          sum = work_q[ia] + work_q[ib];
          step[ia] = sum;
          step[id] = rotl(work_q[id] ^ sum, 8);
        end
        default: begin
          sum = work_q[ic] + work_q[id];
          step[ic] = sum;
          step[ib] = rotl(work_q[ib] ^ sum, 7);
        end
      endcase
    end
  end

  always_comb begin
    state_d = state_q;
    work_d  = work_q;
    sub_d   = sub_q;
    diag_d  = diag_q;
    dr_d    = dr_q;
    case (state_q)
      CORE_IDLE: begin
        if (start_i) begin
          work_d  = init_i;
          sub_d   = '0;
          diag_d  = 1'b0;
          dr_d    = '0;
          state_d = CORE_RUN;
        end
      end
      CORE_RUN: begin
        work_d = step;
        sub_d  = sub_q + 2'd1;
        if (sub_q == 2'd3) begin
          diag_d = !diag_q;
          if (diag_q) begin
            if (dr_q == DrW'(DOUBLE_ROUNDS - 1)) begin
              state_d = CORE_ADD;
            end else begin
              dr_d = dr_q + 1'b1;
            end
          end
        end
      end
      CORE_ADD: begin
        for (int i = 0; i < 16; i++) begin
          work_d[i] = work_q[i] + init_q[i];
        end
        state_d = CORE_IDLE;
      end
      default: state_d = CORE_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= CORE_IDLE;
      sub_q   <= '0;
      diag_q  <= 1'b0;
      dr_q    <= '0;
    end else begin
      state_q <= state_d;
      sub_q   <= sub_d;
      diag_q  <= diag_d;
      dr_q    <= dr_d;
    end
  end

  always_ff @(posedge clk_i) begin
    work_q <= work_d;
    if (state_q == CORE_IDLE && start_i) begin
      init_q <= init_i;
    end
  end

  assign ctl_o.start = (state_q == CORE_IDLE) && start_i;
  assign ctl_o.done  = (state_q == CORE_ADD);
  assign ks_o        = work_q;

endmodule

>>> design/chacha20_stream_cipher.sv
// Top level of the ChaCha20 byte stream cipher: configuration, byte back end and output register.
`timescale 1ns / 1ps
// Each accepted byte comes back XORed with the ChaCha20 keystream, one result per
// transaction, in order. Bytes move through at one per cycle inside a 64-byte block
// while the output is not stalled. At the first byte of every block the block function
// runs first, on the shared round unit that does one quarter-round line per cycle,
// before that byte can leave. A two-entry input queue keeps taking bytes meanwhile.
// The user must write configuration only while the block is idle; the block does not enforce it.
module chacha20_stream_cipher #(
  parameter int unsigned DOUBLE_ROUNDS = cc20_pkg::DoubleRoundsDefault
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic [7:0]                    plain_byte_i,
  input  logic                          last_in_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [7:0]                    cipher_byte_o,
  output logic                          last_out_o,
  input  logic                          cfg_we_i,
  input  logic [cc20_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic [cc20_pkg::CfgDataW-1:0] cfg_data_i
);
  import cc20_pkg::*;

  logic [7:0][31:0] key_q;
  logic [2:0][31:0] nonce_q;
  logic [31:0]      start_q;

  item_t      in_item, head;
  logic       head_valid, pop;
  core_ctl_t  core_ctl;
  block_t     init_blk, ks;
  logic       core_start, core_busy_q;

  logic [5:0]  pos_q;
  logic [31:0] blk_q, blk_cnt;
  logic        ready_q, ks_valid_q;
  logic        out_valid_q, out_free;
  logic [7:0]  cipher_q;
  logic        last_q;
  logic [31:0] ks_word;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key_q   <= '0;
      nonce_q <= '0;
      start_q <= '0;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        CFG_KEY_01:   key_q[1:0]   <= cfg_data_i;
        CFG_KEY_23:   key_q[3:2]   <= cfg_data_i;
        CFG_KEY_45:   key_q[5:4]   <= cfg_data_i;
        CFG_KEY_67:   key_q[7:6]   <= cfg_data_i;
        CFG_NONCE_01: nonce_q[1:0] <= cfg_data_i;
        CFG_NONCE_2:  nonce_q[2]   <= cfg_data_i[31:0];
        CFG_START:    start_q      <= cfg_data_i[31:0];
        default: ;
      endcase
    end
  end

  assign in_item.data = plain_byte_i;
  assign in_item.last = last_in_i;

  cc20_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .item_i      (in_item),
    .head_valid_o(head_valid),
    .head_o      (head),
    .pop_i       (pop)
  );

  // A new message starts from the configured counter; later blocks continue the count.
  assign blk_cnt = ready_q ? blk_q : start_q;

  always_comb begin
    init_blk     = '0;
    init_blk[0]  = SIGMA_0;
    init_blk[1]  = SIGMA_1;
    init_blk[2]  = SIGMA_2;
    init_blk[3]  = SIGMA_3;
    for (int i = 0; i < 8; i++) begin
      init_blk[4 + i] = key_q[i];
    end
    init_blk[12] = blk_cnt;
    init_blk[13] = nonce_q[0];
    init_blk[14] = nonce_q[1];
    init_blk[15] = nonce_q[2];
  end

  assign core_start = head_valid && !ks_valid_q && !core_busy_q;

  cc20_core #(
    .DOUBLE_ROUNDS(DOUBLE_ROUNDS)
  ) u_core (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .init_i (init_blk),
    .start_i(core_start),
    .ctl_o  (core_ctl),
    .ks_o   (ks)
  );

  assign out_free = !out_valid_q || !out_stall_i;
  assign pop      = ks_valid_q && head_valid && out_free;
  assign ks_word  = ks[pos_q[5:2]];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q       <= '0;
      blk_q       <= '0;
      ready_q     <= 1'b0;
      ks_valid_q  <= 1'b0;
      core_busy_q <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (core_ctl.start) begin
        core_busy_q <= 1'b1;
        blk_q       <= blk_cnt;
        ready_q     <= 1'b1;
      end
      if (core_ctl.done) begin
        core_busy_q <= 1'b0;
        ks_valid_q  <= 1'b1;
      end
      if (out_free) begin
        out_valid_q <= pop;
      end
      if (pop) begin
        pos_q <= pos_q + 6'd1;
        if (pos_q == 6'd63) begin
          blk_q      <= blk_q + 32'd1;
          ks_valid_q <= 1'b0;
        end
        if (head.last) begin
          pos_q      <= '0;
          ready_q    <= 1'b0;
          ks_valid_q <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop) begin
      cipher_q <= head.data ^ ks_word[{pos_q[1:0], 3'b000} +: 8];
      last_q   <= head.last;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign cipher_byte_o = cipher_q;
  assign last_out_o    = last_q;

  a_start_needs_empty_ks : assert property (@(posedge clk_i) disable iff (!rst_ni)
    core_ctl.start |-> !ks_valid_q && pos_q == 6'd0)
    else $error("block function started while keystream block still in use");

  a_idle_pos_zero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !ready_q |-> pos_q == 6'd0)
    else $error("byte position nonzero outside a message");

  a_done_when_busy : assert property (@(posedge clk_i) disable iff (!rst_ni)
    core_ctl.done |-> core_busy_q && !ks_valid_q)
    else $error("block function finished without being started");

endmodule

>>> sim/chacha20_stream_cipher_tb.sv
// Self-checking testbench for the ChaCha20 byte stream cipher.
`timescale 1ns / 1ps
module chacha20_stream_cipher_tb;
  import cc20_pkg::*;

  localparam int unsigned CycleLimit = 600000;
  localparam int unsigned SettleCycles = 120;

  typedef logic [15:0][31:0] state_words_t;
  typedef struct {
    logic [7:0] cipher;
    logic       last;
  } cipher_exp_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_stall_o;
  logic [7:0] plain_byte_i = '0;
  logic last_in_i = 1'b0;
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  logic [7:0] cipher_byte_o;
  logic last_out_o;
  logic cfg_we_i = 1'b0;
  logic [CfgIdxW-1:0] cfg_index_i = '0;
  logic [CfgDataW-1:0] cfg_data_i = '0;

  // Predictor copy of the configuration and the keystream state.
  logic [31:0] key_q [8];
  logic [31:0] nonce_q [3];
  logic [31:0] start_q;
  state_words_t keystream_q;
  logic [5:0] byte_pos_q;
  logic [31:0] block_ctr_q;
  logic in_message_q;

  cipher_exp_t expected_q [$];
  int unsigned errors = 0;
  int unsigned cycles = 0;
  int unsigned items_sent = 0;
  int unsigned results_seen = 0;
  int unsigned send_idle_pct = 0;
  int unsigned recv_stall_pct = 0;

  chacha20_stream_cipher dut (.*);

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("Timeout after %0d cycles", cycles);
      $display("Simulation FAILED");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    out_stall_i <= ($urandom_range(99) < recv_stall_pct);
  end

  function automatic logic [31:0] rot_left(logic [31:0] x, int unsigned n);
    return (x << n) | (x >> (32 - n));
  endfunction

  function automatic state_words_t quarter_mix(state_words_t w, int a, int b, int c, int d);
    w[a] += w[b]; w[d] = rot_left(w[d] ^ w[a], 16);
    w[c] += w[d]; w[b] = rot_left(w[b] ^ w[c], 12);
    w[a] += w[b]; w[d] = rot_left(w[d] ^ w[a], 8);
    w[c] += w[d]; w[b] = rot_left(w[b] ^ w[c], 7);
    return w;
  endfunction

  function automatic state_words_t chacha_block(logic [31:0] ctr);
    state_words_t init;
    state_words_t work;
    init[0] = SIGMA_0; init[1] = SIGMA_1; init[2] = SIGMA_2; init[3] = SIGMA_3;
    for (int i = 0; i < 8; i++) init[4 + i] = key_q[i];
    init[12] = ctr;
    for (int i = 0; i < 3; i++) init[13 + i] = nonce_q[i];
    work = init;
    for (int r = 0; r < DoubleRoundsDefault; r++) begin
      work = quarter_mix(work, 0, 4, 8, 12);
      work = quarter_mix(work, 1, 5, 9, 13);
      work = quarter_mix(work, 2, 6, 10, 14);
      work = quarter_mix(work, 3, 7, 11, 15);
      work = quarter_mix(work, 0, 5, 10, 15);
      work = quarter_mix(work, 1, 6, 11, 12);
      work = quarter_mix(work, 2, 7, 8, 13);
      work = quarter_mix(work, 3, 4, 9, 14);
    end
    for (int i = 0; i < 16; i++) work[i] += init[i];
    return work;
  endfunction

  // Advances the cipher state by one byte and queues the expected output.
  function automatic void predict_cipher(logic [7:0] plain, logic last);
    cipher_exp_t exp_item;
    logic [7:0] ks_byte;
    if (byte_pos_q == 0) begin
      if (!in_message_q) block_ctr_q = start_q;
      keystream_q = chacha_block(block_ctr_q);
      in_message_q = 1'b1;
    end
    ks_byte = 8'(keystream_q[byte_pos_q[5:2]] >> (8 * byte_pos_q[1:0]));
    exp_item.cipher = plain ^ ks_byte;
    exp_item.last = last;
    expected_q.push_back(exp_item);
    byte_pos_q = byte_pos_q + 6'd1;
    if (byte_pos_q == 0) block_ctr_q = block_ctr_q + 32'd1;
    if (last) begin
      byte_pos_q = '0;
      in_message_q = 1'b0;
    end
  endfunction

  // Signals settle between rising edges, so both sides are sampled at the falling edge.
  always @(negedge clk_i) begin
    cipher_exp_t exp_item;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      results_seen++;
      if (expected_q.size() == 0) begin
        $error("Unexpected result: cipher_byte %h last_out %b", cipher_byte_o, last_out_o);
        errors++;
      end else begin
        exp_item = expected_q.pop_front();
        if (cipher_byte_o !== exp_item.cipher) begin
          $error("cipher_byte: expected %h, actual %h", exp_item.cipher, cipher_byte_o);
          errors++;
        end
        if (last_out_o !== exp_item.last) begin
          $error("last_out: expected %b, actual %b", exp_item.last, last_out_o);
          errors++;
        end
      end
    end
  end

  task automatic write_reg(logic [CfgIdxW-1:0] idx, logic [CfgDataW-1:0] data);
    @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= data;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      CFG_KEY_01, CFG_KEY_23, CFG_KEY_45, CFG_KEY_67: begin
        key_q[2 * idx] = data[31:0];
        key_q[2 * idx + 1] = data[63:32];
      end
      CFG_NONCE_01: begin
        nonce_q[0] = data[31:0];
        nonce_q[1] = data[63:32];
      end
      CFG_NONCE_2: nonce_q[2] = data[31:0];
      CFG_START: start_q = data[31:0];
      default: ;
    endcase
  endtask

  task automatic load_config(logic [255:0] key, logic [95:0] nonce, logic [31:0] start);
    write_reg(CFG_KEY_01, key[63:0]);
    write_reg(CFG_KEY_23, key[127:64]);
    write_reg(CFG_KEY_45, key[191:128]);
    write_reg(CFG_KEY_67, key[255:192]);
    write_reg(CFG_NONCE_01, nonce[63:0]);
    write_reg(CFG_NONCE_2, {32'h0, nonce[95:64]});
    write_reg(CFG_START, {32'h0, start});
  endtask

  // Leaves in_valid_i high on return so back-to-back bytes need no extra edge.
  task automatic send_byte(logic [7:0] plain, logic last);
    bit taken;
    // Each pass of this loop leaves the input idle, with a chance set by the percentage.
    while ($urandom_range(99) < send_idle_pct) begin
      @(posedge clk_i);
      in_valid_i <= 1'b0;
    end
    @(posedge clk_i);
    in_valid_i <= 1'b1;
    plain_byte_i <= plain;
    last_in_i <= last;
    do begin
      @(negedge clk_i);
      taken = !in_stall_o;
    end while (!taken);
    predict_cipher(plain, last);
    items_sent++;
  endtask

  // The sender holds off until every result is back and the block has settled.
  task automatic drain;
    @(posedge clk_i);
    in_valid_i <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic send_message(int unsigned len);
    for (int unsigned i = 0; i < len; i++) send_byte(8'($urandom_range(255)), i == len - 1);
  endtask

  task automatic random_key_config;
    load_config({$urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
                 $urandom}, {$urandom, $urandom, $urandom}, $urandom);
  endtask

  task automatic test_directed;
    logic [7:0] edge_bytes [4] = '{8'h00, 8'hFF, 8'hAA, 8'h55};
    // Single-byte messages at reset configuration restart the keystream each time.
    foreach (edge_bytes[i]) send_byte(edge_bytes[i], 1'b1);
    send_byte(8'h00, 1'b0);
    send_byte(8'hFF, 1'b0);
    send_byte(8'h0F, 1'b1);
    drain();
    load_config({256{1'b1}}, {96{1'b1}}, 32'hFFFF_FFFF);
    foreach (edge_bytes[i]) send_byte(edge_bytes[i], i[0]);
    send_byte(8'hF0, 1'b1);
    drain();
  endtask

  task automatic test_bad_index;
    // Index seven is not a register; the key stream must not change.
    write_reg(CfgIdxW'(7), {64{1'b1}});
    load_config('0, '0, 32'h0);
    write_reg(CfgIdxW'(7), 64'h1234_5678_9ABC_DEF0);
    send_message(5);
    drain();
  endtask

  task automatic test_counter_wrap;
    random_key_config();
    write_reg(CFG_START, 64'hFFFF_FFFF_FFFF_FFFE);
    send_message(140);
    drain();
  endtask

  task automatic test_random_phase(int unsigned n_items, int unsigned idle, int unsigned stall);
    int unsigned sent;
    int unsigned len;
    send_idle_pct = idle;
    recv_stall_pct = stall;
    random_key_config();
    sent = 0;
    while (sent < n_items) begin
      len = ($urandom_range(9) == 0) ? $urandom_range(65, 140) : $urandom_range(1, 70);
      send_message(len);
      sent += len;
      if ($urandom_range(4) == 0) begin
        drain();
        random_key_config();
      end
    end
    drain();
  endtask

  initial begin
    foreach (key_q[i]) key_q[i] = '0;
    foreach (nonce_q[i]) nonce_q[i] = '0;
    start_q = '0;
    keystream_q = '0;
    byte_pos_q = '0;
    block_ctr_q = '0;
    in_message_q = 1'b0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);
    send_idle_pct = 30;
    recv_stall_pct = 66;
    test_directed();
    test_bad_index();
    test_counter_wrap();
    test_random_phase(160, 30, 66);
    test_random_phase(160, 66, 30);
    test_random_phase(160, 0, 0);
    drain();
    $display("Covered %0d bytes and %0d results over several keys, nonces and counters,",
             items_sent, results_seen);
    $display("including counter wrap, multi-block messages and an unused register index.");
    if (errors == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
